// ----- sv/bqmc_pkg.sv -----
// Shared types, constants and codes for the multichannel biquad core.
package bqmc_pkg;

	localparam int CHANNELS = 2;
	localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

	localparam int SAMPLE_W = 24;
	localparam int COEF_W = 32;
	localparam int STATE_W = 48;
	localparam int FB_W = 31;                   // feedback sample, Q8.23
	localparam int PROD_W = COEF_W + FB_W;      // exact product width
	localparam int PSH_W = PROD_W - 11;         // product shifted to Q.40
	localparam int ACC_W = 54;                  // headroom for three-term sums
	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_B0 = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1 = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2 = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_A1 = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_A2 = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_EQ = 3'd5;

	typedef struct packed {
		logic                       chan;
		logic signed [SAMPLE_W-1:0] sample_in;
	} in_item_t;

	typedef struct packed {
		logic                       chan_out;
		logic signed [SAMPLE_W-1:0] sample_out;
	} out_item_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_B0,
		ST_Y,
		ST_A1,
		ST_B2,
		ST_A2,
		ST_WB
	} bqmc_state_t;

	// coefficient fed to the shared multiplier
	typedef enum logic [2:0] {
		MUL_B0,
		MUL_B1,
		MUL_B2,
		MUL_A1,
		MUL_A2
	} mul_sel_t;

	// accumulator step for the current cycle
	typedef enum logic [2:0] {
		DP_NONE,
		DP_Y,
		DP_N1A,
		DP_N1B,
		DP_N2A,
		DP_WB
	} dp_op_t;

	typedef struct packed {
		logic     load;
		logic     mul_en;
		mul_sel_t mul_sel;
		dp_op_t   op;
	} bqmc_cmd_t;

endpackage

// ----- sv/bqmc_ctrl.sv -----
// Sequencer for the biquad core: steps the shared multiplier and owns the output valid.
module bqmc_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	output bqmc_pkg::bqmc_cmd_t cmd
);

	bqmc_pkg::bqmc_state_t state_q, state_d;
	logic out_valid_q;
	logic wb_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bqmc_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (wb_fire) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		in_ready = 1'b0;
		wb_fire = 1'b0;
		cmd.load = 1'b0;
		cmd.mul_en = 1'b0;
		cmd.mul_sel = bqmc_pkg::MUL_B0;
		cmd.op = bqmc_pkg::DP_NONE;
		unique case (state_q)
			bqmc_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = bqmc_pkg::ST_B0;
				end
			end
			bqmc_pkg::ST_B0: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = bqmc_pkg::MUL_B0;
				state_d = bqmc_pkg::ST_Y;
			end
			bqmc_pkg::ST_Y: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = bqmc_pkg::MUL_B1;
				cmd.op = bqmc_pkg::DP_Y;
				state_d = bqmc_pkg::ST_A1;
			end
			bqmc_pkg::ST_A1: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = bqmc_pkg::MUL_A1;
				cmd.op = bqmc_pkg::DP_N1A;
				state_d = bqmc_pkg::ST_B2;
			end
			bqmc_pkg::ST_B2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = bqmc_pkg::MUL_B2;
				cmd.op = bqmc_pkg::DP_N1B;
				state_d = bqmc_pkg::ST_A2;
			end
			bqmc_pkg::ST_A2: begin
				cmd.mul_en = 1'b1;
				cmd.mul_sel = bqmc_pkg::MUL_A2;
				cmd.op = bqmc_pkg::DP_N2A;
				state_d = bqmc_pkg::ST_WB;
			end
			bqmc_pkg::ST_WB: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					wb_fire = 1'b1;
					cmd.op = bqmc_pkg::DP_WB;
					state_d = bqmc_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = bqmc_pkg::ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule

// ----- sv/bqmc_dp.sv -----
// Datapath of the biquad core: coefficients, shared multiplier, accumulators, channel state.
module bqmc_dp (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  bqmc_pkg::bqmc_cmd_t                    cmd,
	input  bqmc_pkg::in_item_t                     in_data,
	output bqmc_pkg::out_item_t                    out_data,
	input  logic                                   cfg_wr_en,
	input  logic [bqmc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [bqmc_pkg::COEF_W-1:0]            cfg_data
);

	localparam int SW = bqmc_pkg::SAMPLE_W;
	localparam int CW = bqmc_pkg::COEF_W;
	localparam int ZW = bqmc_pkg::STATE_W;
	localparam int FW = bqmc_pkg::FB_W;
	localparam int PW = bqmc_pkg::PROD_W;
	localparam int HW = bqmc_pkg::PSH_W;
	localparam int AW = bqmc_pkg::ACC_W;
	localparam int IW = bqmc_pkg::IDX_W;

	function automatic logic signed [ZW-1:0] sat_state(input logic signed [AW-1:0] v);
		logic signed [ZW-1:0] r;
		if (v[AW-1:ZW-1] == {(AW-ZW+1){1'b0}} || v[AW-1:ZW-1] == {(AW-ZW+1){1'b1}}) begin
			r = v[ZW-1:0];
		end else if (v[AW-1]) begin
			r = {1'b1, {(ZW-1){1'b0}}};
		end else begin
			r = {1'b0, {(ZW-1){1'b1}}};
		end
		return r;
	endfunction

	function automatic logic signed [SW-1:0] sat_sample(input logic signed [FW-1:0] v);
		logic signed [SW-1:0] r;
		if (v[FW-1:SW-1] == {(FW-SW+1){1'b0}} || v[FW-1:SW-1] == {(FW-SW+1){1'b1}}) begin
			r = v[SW-1:0];
		end else if (v[FW-1]) begin
			r = {1'b1, {(SW-1){1'b0}}};
		end else begin
			r = {1'b0, {(SW-1){1'b1}}};
		end
		return r;
	endfunction

	logic signed [CW-1:0] b0_q, b1_q, b2_q, a1_q, a2_q;
	logic                 eq_q;

	logic signed [SW-1:0] x_q;
	logic                 ch_q;
	logic                 ch_ok;
	logic [IW-1:0]        idx;

	logic signed [ZW-1:0] d1_q [bqmc_pkg::CHANNELS];
	logic signed [ZW-1:0] d2_q [bqmc_pkg::CHANNELS];
	logic signed [ZW-1:0] d1_rd, d2_rd;

	logic signed [CW-1:0] mul_a;
	logic signed [FW-1:0] mul_b;
	logic signed [PW-1:0] prod;
	logic signed [PW-1:0] prod_q;
	logic signed [AW-1:0] psx;

	logic signed [FW-1:0] yf_q;
	logic signed [AW-1:0] acc1_q, acc2_q;
	logic signed [AW-1:0] sum_y, n2;
	logic signed [ZW-1:0] acc_y;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			b0_q <= 32'sh1000_0000;
			b1_q <= '0;
			b2_q <= '0;
			a1_q <= '0;
			a2_q <= '0;
			eq_q <= 1'b1;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				bqmc_pkg::REG_B0: b0_q <= cfg_data;
				bqmc_pkg::REG_B1: b1_q <= cfg_data;
				bqmc_pkg::REG_B2: b2_q <= cfg_data;
				bqmc_pkg::REG_A1: a1_q <= cfg_data;
				bqmc_pkg::REG_A2: a2_q <= cfg_data;
				bqmc_pkg::REG_EQ: eq_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// input capture
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q <= in_data.sample_in;
			ch_q <= in_data.chan;
		end
	end

	assign ch_ok = (32'(ch_q) < bqmc_pkg::CHANNELS);
	assign idx = IW'(ch_q);
	assign d1_rd = ch_ok ? d1_q[idx] : '0;
	assign d2_rd = ch_ok ? d2_q[idx] : '0;

	// shared multiplier, one product per cycle while cmd.mul_en is set
	always_comb begin
		mul_a = b0_q;
		mul_b = FW'(x_q);
		unique case (cmd.mul_sel)
			bqmc_pkg::MUL_B0: begin
				mul_a = b0_q;
				mul_b = FW'(x_q);
			end
			bqmc_pkg::MUL_B1: begin
				mul_a = b1_q;
				mul_b = FW'(x_q);
			end
			bqmc_pkg::MUL_B2: begin
				mul_a = b2_q;
				mul_b = FW'(x_q);
			end
			bqmc_pkg::MUL_A1: begin
				mul_a = a1_q;
				mul_b = yf_q;
			end
			bqmc_pkg::MUL_A2: begin
				mul_a = a2_q;
				mul_b = yf_q;
			end
			default: begin
			end
		endcase
	end

	assign prod = PW'(mul_a) * PW'(mul_b);

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			prod_q <= prod;
		end
	end

	// dropping 11 low bits of a signed product is the floor shift to Q.40
	assign psx = AW'(signed'(prod_q[PW-1:PW-HW]));

	assign sum_y = psx + AW'(d1_rd);
	assign acc_y = sat_state(sum_y);
	assign n2 = acc2_q - psx;

	always_ff @(posedge clk) begin
		unique case (cmd.op)
			bqmc_pkg::DP_Y:   yf_q <= acc_y[ZW-1:ZW-FW];
			bqmc_pkg::DP_N1A: acc1_q <= psx + AW'(d2_rd);
			bqmc_pkg::DP_N1B: acc1_q <= acc1_q - psx;
			bqmc_pkg::DP_N2A: acc2_q <= psx;
			bqmc_pkg::DP_WB: begin
				out_data.chan_out <= ch_q;
				out_data.sample_out <= (eq_q && ch_ok) ? sat_sample(yf_q) : x_q;
			end
			default: begin
			end
		endcase
	end

	// channel delay state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < bqmc_pkg::CHANNELS; i++) begin
				d1_q[i] <= '0;
				d2_q[i] <= '0;
			end
		end else if (cmd.op == bqmc_pkg::DP_WB && ch_ok) begin
			d1_q[idx] <= sat_state(acc1_q);
			d2_q[idx] <= sat_state(n2);
		end
	end

endmodule

// ----- sv/biquad_tdf2_multichannel_core.sv -----
// Top level of the multichannel transposed direct form II biquad core.
//
//   channel   direction  handshake              payload
//   in        in         in_valid / in_ready    in_data  (chan, sample_in)
//   out       out        out_valid / out_ready  out_data (chan_out, sample_out)
//   cfg       in         cfg_wr_en              cfg_index, cfg_data
//
// A transaction is accepted in the idle step and its result is built in six
// steps: five products through one shared 32x31 multiplier, each registered
// and accumulated in the step that follows it, then the write-back. A new item
// is accepted only after the previous one has left write-back.
// Reset clears the sequencer, the output valid and all channel state, and loads
// the coefficient defaults (b0 = 1.0, bypass off). A stalled output holds the
// item in write-back; channel state is written only when it moves to the output.
module biquad_tdf2_multichannel_core (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  bqmc_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_ready,
	output bqmc_pkg::out_item_t            out_data,
	input  logic                           cfg_wr_en,
	input  logic [bqmc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bqmc_pkg::COEF_W-1:0]    cfg_data
);

	bqmc_pkg::bqmc_cmd_t cmd;

	// sequencer: walks the multiply and accumulate steps
	bqmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd)
	);

	// datapath: coefficients, multiplier, accumulators and channel state
	bqmc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.in_data   (in_data),
		.out_data  (out_data),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// one item in flight: an accepted transaction drops ready the next cycle
	a_one_in_flight : assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input accepted while an item is in flight");

	// write-back never overwrites a result that is still waiting
	a_no_overwrite : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bqmc_pkg::DP_WB |-> !out_valid || out_ready)
		else $error("write-back over a pending result");

	// write-back always presents a result in the next cycle
	a_wb_valid : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == bqmc_pkg::DP_WB |=> out_valid)
		else $error("write-back without a result");

	// the input is only captured while ready is high
	a_load_ready : assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> in_ready && in_valid)
		else $error("input captured outside a transaction");

endmodule
